// ===== design/pwtt_pkg.sv =====
// Shared types and constants for the host window descriptor table translator.
package pwtt_pkg;

   // Table geometry
   localparam int unsigned TABLE_ENTRIES_DEF = 186;

   // Item operations
   typedef enum logic [1:0] {
      OP_TRANSLATE  = 2'd0,
      OP_WRITE_HALF = 2'd1,
      OP_WRITE_FULL = 2'd2
   } op_type;

   // Result status codes
   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_OVERRUN  = 3'd1,
      ST_RESERVED = 3'd2,
      ST_ORDER3   = 3'd3,
      ST_BADWRITE = 3'd4
   } status_type;

   // Window size class
   typedef enum logic [1:0] {
      WIN_1M  = 2'd0,
      WIN_2M  = 2'd1,
      WIN_16M = 2'd2
   } win_type;

   // Window area map
   localparam logic [28:0] SMALL_END       = 29'h9C0_0000;
   localparam logic [28:0] MID_END         = 29'hB00_0000;
   localparam logic [25:0] SMALL_SPAN      = 26'h010_0000;
   localparam logic [25:0] MID_SPAN        = 26'h020_0000;
   localparam logic [25:0] LARGE_SPAN      = 26'h100_0000;
   localparam logic [7:0]  MID_BASE_IDX    = 8'd156;
   localparam logic [7:0]  LARGE_BASE_IDX  = 8'd166;

   // Descriptor bits above the address field that may be set
   localparam logic [63:0] ALLOWED_HIGH    = 64'h0000_0000_2C00_0FFF;
   localparam int unsigned ORD_LSB         = 26;
   localparam int unsigned COORD_W         = 12;
   localparam int unsigned LOCAL_ADDR_W    = 36;
   localparam logic [1:0]  ORDER_RESERVED  = 2'd3;

   // Stream payload widths
   localparam int unsigned REQ_DATA_W = 120;
   localparam int unsigned RSP_DATA_W = 56;

endpackage

// ===== design/pwtt_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module pwtt_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 186
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/pcie_window_tlb_translate.sv =====
// An accepted request waits in stage A while its descriptor is read, then moves
// into the output register. A new request is taken only once stage A is empty;
// the descriptor is read at accept and written back (read-modify-write) as it leaves A.
// Reset (synchronous, active high) clears the per-entry valid bits, so the whole
// table reads as zero at once; no clearing pass is needed.
// Output register decouples rsp stalls from the request side.
module pcie_window_tlb_translate
   import pwtt_pkg::*;
#(
   parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [1:0] operation
   input  logic [1:0]            req_tuser,
   // [28:0] byte_offset, [53:29] access_size, [117:54] write_data
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [11:0] target_coord, [47:12] target_addr, [49:48] ordering_mode, [52:50] status
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int unsigned AddrW = $clog2(TABLE_ENTRIES);

   // Request fields
   logic [1:0]  req_op;
   logic [28:0] req_off;
   logic [24:0] req_size;
   logic [63:0] req_wdata;

   assign req_op    = req_tuser;
   assign req_off   = req_tdata[28:0];
   assign req_size  = req_tdata[53:29];
   assign req_wdata = req_tdata[117:54];

   // Stage A: item whose descriptor read is in flight
   logic                     a_vld_ff, a_vld_in;
   logic [1:0]               a_op_ff;
   logic [AddrW-1:0]         a_idx_ff;
   win_type                  a_win_ff;
   logic [23:0]              a_inwin_ff;
   logic                     a_err_ff;
   logic                     a_hi_ff;
   logic [63:0]              a_data_ff;

   // Output register
   logic                     rsp_vld_ff, rsp_vld_in;
   logic [RSP_DATA_W-1:0]    rsp_data_ff, rsp_data_in;

   // Per-entry valid bits; an entry never written reads as zero
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;

   logic req_fire, advance;

   assign req_tready = !a_vld_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign advance    = a_vld_ff && (!rsp_vld_ff || rsp_tready);

   // Decode at accept: window class, entry index, in-window offset, errors
   logic [7:0]       tr_idx;
   win_type          tr_win;
   logic [23:0]      tr_inwin;
   logic [25:0]      tr_span;
   logic [28:0]      tr_rel;
   logic [25:0]      tr_end;
   logic             tr_err;
   logic             wr_in_range;
   logic             dec_err;
   logic [AddrW-1:0] dec_idx;
   logic             dec_rd;

   always_comb begin
      tr_rel = '0;
      if (req_off < SMALL_END) begin
         tr_win   = WIN_1M;
         tr_idx   = req_off[27:20];
         tr_inwin = {4'b0, req_off[19:0]};
         tr_span  = SMALL_SPAN;
      end else if (req_off < MID_END) begin
         tr_rel   = req_off - SMALL_END;
         tr_win   = WIN_2M;
         tr_idx   = MID_BASE_IDX + {4'b0, tr_rel[24:21]};
         tr_inwin = {3'b0, req_off[20:0]};
         tr_span  = MID_SPAN;
      end else begin
         tr_rel   = req_off - MID_END;
         tr_win   = WIN_16M;
         tr_idx   = LARGE_BASE_IDX + {3'b0, tr_rel[28:24]};
         tr_inwin = req_off[23:0];
         tr_span  = LARGE_SPAN;
      end
      tr_end = {2'b0, tr_inwin} + {1'b0, req_size};
      tr_err = (32'(tr_idx) >= TABLE_ENTRIES) || (req_size == '0) || (tr_end > tr_span);
      wr_in_range = 32'(req_off[28:3]) < TABLE_ENTRIES;
   end

   always_comb begin
      dec_err = 1'b1;
      dec_idx = req_off[AddrW+2:3];
      unique case (req_op)
         OP_TRANSLATE: begin
            dec_err = tr_err;
            dec_idx = tr_idx[AddrW-1:0];
         end
         OP_WRITE_HALF: dec_err = (req_off[1:0] != 2'b0) || !wr_in_range;
         OP_WRITE_FULL: dec_err = (req_off[2:0] != 3'b0) || !wr_in_range;
         default:       dec_err = 1'b1;
      endcase
      dec_rd = req_fire && !dec_err;
   end

   // Stage A registers
   always_comb begin
      a_vld_in = a_vld_ff;
      if (req_fire) begin
         a_vld_in = 1'b1;
      end else if (advance) begin
         a_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= a_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         a_op_ff    <= req_op;
         a_idx_ff   <= dec_idx;
         a_win_ff   <= tr_win;
         a_inwin_ff <= tr_inwin;
         a_err_ff   <= dec_err;
         a_hi_ff    <= req_off[2];
         a_data_ff  <= req_wdata;
      end
   end

   // Descriptor store
   logic [63:0] ram_rdata;
   logic        ram_we;
   logic [63:0] ram_wdata;

   pwtt_ram #(
      .WIDTH (64),
      .DEPTH (TABLE_ENTRIES)
   ) u_desc_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (a_idx_ff),
      .wr_data (ram_wdata),
      .rd_en   (dec_rd),
      .rd_addr (dec_idx),
      .rd_data (ram_rdata)
   );

   // Stage B: merge writes, check and form translations
   logic [63:0] entry;
   logic [63:0] high;
   logic [35:0] xl_addr;
   logic        rsvd;
   logic [1:0]  ord;
   status_type  st;
   logic [11:0] o_coord;
   logic [35:0] o_addr;
   logic [1:0]  o_ord;

   always_comb begin
      entry = valid_ff[a_idx_ff] ? ram_rdata : 64'b0;
      case (a_win_ff)
         WIN_1M: begin
            high    = entry >> 16;
            xl_addr = {entry[15:0], a_inwin_ff[19:0]};
         end
         WIN_2M: begin
            high    = entry >> 15;
            xl_addr = {entry[14:0], a_inwin_ff[20:0]};
         end
         default: begin
            high    = entry >> 12;
            xl_addr = {entry[11:0], a_inwin_ff[23:0]};
         end
      endcase
      rsvd = |(high & ~ALLOWED_HIGH);
      ord  = high[ORD_LSB+1:ORD_LSB];
   end

   always_comb begin
      ram_wdata = a_data_ff;
      if (a_op_ff == OP_WRITE_HALF) begin
         ram_wdata = a_hi_ff ? {a_data_ff[31:0], entry[31:0]} : {entry[63:32], a_data_ff[31:0]};
      end
      ram_we = advance && !a_err_ff
               && (a_op_ff == OP_WRITE_HALF || a_op_ff == OP_WRITE_FULL);
   end

   always_comb begin
      o_coord = '0;
      o_addr  = '0;
      o_ord   = '0;
      unique case (a_op_ff)
         OP_TRANSLATE: begin
            if (a_err_ff) begin
               st = ST_OVERRUN;
            end else if (rsvd) begin
               st = ST_RESERVED;
            end else if (ord == ORDER_RESERVED) begin
               st = ST_ORDER3;
            end else begin
               st      = ST_OK;
               o_coord = high[COORD_W-1:0];
               o_addr  = xl_addr;
               o_ord   = ord;
            end
         end
         OP_WRITE_HALF, OP_WRITE_FULL: st = a_err_ff ? ST_BADWRITE : ST_OK;
         default:                      st = ST_BADWRITE;
      endcase
      rsp_data_in = {3'b0, st, o_ord, o_addr, o_coord};
   end

   // Valid bits follow completed writes
   always_comb begin
      valid_in = valid_ff;
      if (ram_we) begin
         valid_in[a_idx_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Output register
   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (advance) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // An error status never carries translation fields
   assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_data_ff[52:50] != ST_OK) |-> (rsp_data_ff[49:0] == '0))
      else $error("error response with nonzero payload");

   // Reset leaves the whole table reading as zero
   assert property (@(posedge clock) $past(reset) |-> (valid_ff == '0))
      else $error("valid bits not cleared by reset");

   // A committed write marks its entry valid
   assert property (@(posedge clock) disable iff (reset)
      ram_we |=> valid_ff[$past(a_idx_ff)])
      else $error("written entry not marked valid");

   // An accepted transfer always occupies the read stage next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (a_vld_ff && !req_tready))
      else $error("accepted item lost from read stage");
`endif

endmodule

// ===== verif/pwtt_checker.sv =====
`timescale 1ns / 100ps
// Checker for the window descriptor translator: shadows the descriptor table and compares responses.
module pwtt_checker
   import pwtt_pkg::*;
#(
   parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [1:0]            req_tuser,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   output int                    fail_count,
   output int                    outstanding
);

   // Window area boundaries and the descriptor bits above the address field that may be set
   localparam logic [28:0] AREA_1M_END  = 29'h9C0_0000;
   localparam logic [28:0] AREA_2M_END  = 29'hB00_0000;
   localparam logic [63:0] HIGH_ALLOWED = 64'h0000_0000_2C00_0FFF;

   // Response fields, lowest bit last
   typedef struct packed {
      logic [2:0]  status;
      logic [1:0]  ordering;
      logic [35:0] addr;
      logic [11:0] coord;
   } xlat_resp_type;

   logic [63:0]   shadow_table [TABLE_ENTRIES];
   xlat_resp_type predicted_resps [$];

   // Map a BAR offset through the shadow table
   function automatic xlat_resp_type translate_access(input logic [28:0] offset,
                                                      input logic [24:0] size);
      xlat_resp_type r;
      logic [28:0] base;
      int unsigned shift;
      int unsigned addr_w;
      int unsigned idx;
      logic [63:0] mask;
      logic [63:0] inwin;
      logic [63:0] desc;
      logic [63:0] high;
      logic [63:0] full_addr;
      r = '0;
      if (offset < AREA_1M_END) begin
         base = '0;          shift = 20; idx = 0;
      end else if (offset < AREA_2M_END) begin
         base = AREA_1M_END; shift = 21; idx = 156;
      end else begin
         base = AREA_2M_END; shift = 24; idx = 166;
      end
      idx   = idx + ((offset - base) >> shift);
      mask  = (64'd1 << shift) - 64'd1;
      inwin = 64'(offset) & mask;
      // overrun wins over any descriptor problem
      if (idx >= TABLE_ENTRIES || size == '0 || inwin + 64'(size) - 64'd1 > mask) begin
         r.status = ST_OVERRUN;
         return r;
      end
      desc   = shadow_table[idx];
      addr_w = LOCAL_ADDR_W - shift;
      high   = desc >> addr_w;
      if ((high & ~HIGH_ALLOWED) != '0) begin
         r.status = ST_RESERVED;
         return r;
      end
      if (high[27:26] == ORDER_RESERVED) begin
         r.status = ST_ORDER3;
         return r;
      end
      full_addr  = ((desc & ((64'd1 << addr_w) - 64'd1)) << shift) | inwin;
      r.coord    = high[11:0];
      r.addr     = full_addr[35:0];
      r.ordering = high[27:26];
      r.status   = ST_OK;
      return r;
   endfunction

   // Apply one request to the shadow table and return the response it should give
   function automatic xlat_resp_type process_request(input logic [1:0] op,
                                                     input logic [REQ_DATA_W-1:0] item);
      xlat_resp_type r;
      logic [28:0] offset;
      logic [24:0] size;
      logic [63:0] data;
      int unsigned idx;
      offset = item[28:0];
      size   = item[53:29];
      data   = item[117:54];
      idx    = offset >> 3;
      r      = '0;
      r.status = ST_BADWRITE;
      case (op)
         OP_TRANSLATE: begin
            r = translate_access(offset, size);
         end
         OP_WRITE_HALF: begin
            if (offset[1:0] == 2'd0 && idx < TABLE_ENTRIES) begin
               if (offset[2]) shadow_table[idx][63:32] = data[31:0];
               else           shadow_table[idx][31:0]  = data[31:0];
               r.status = ST_OK;
            end
         end
         OP_WRITE_FULL: begin
            if (offset[2:0] == 3'd0 && idx < TABLE_ENTRIES) begin
               shadow_table[idx] = data;
               r.status = ST_OK;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic compare_field(input string field, input logic [63:0] want,
                                input logic [63:0] got, inout int errs);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
         errs++;
      end
   endtask

   // Watch both channels; a request is predicted before any response at the same edge
   always @(posedge clock) begin
      int            errs;
      xlat_resp_type want;
      xlat_resp_type got;
      errs = 0;
      if (reset) begin
         foreach (shadow_table[i]) shadow_table[i] = '0;
         predicted_resps.delete();
         fail_count <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            predicted_resps.push_back(process_request(req_tuser, req_tdata));
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[52:0];
            if (predicted_resps.size() == 0) begin
               $error("response transfer 0x%0h with nothing predicted", rsp_tdata);
               errs++;
            end else begin
               want = predicted_resps.pop_front();
               compare_field("target_coord",  64'(want.coord),    64'(got.coord),    errs);
               compare_field("target_addr",   64'(want.addr),     64'(got.addr),     errs);
               compare_field("ordering_mode", 64'(want.ordering), 64'(got.ordering), errs);
               compare_field("status",        64'(want.status),   64'(got.status),   errs);
            end
         end
         fail_count <= fail_count + errs;
      end
      outstanding <= predicted_resps.size();
   end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// Top of the translator testbench: clock, reset, request stimulus, response back-pressure, verdict.
module tb_top;
   import pwtt_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 180;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [1:0]            req_tuser;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   int                    fail_count;
   int                    outstanding;
   int                    cycle_count = 0;
   int                    sender_idle_pct;
   int                    receiver_idle_pct;

   pcie_window_tlb_translate u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   pwtt_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("pcie_window_tlb_translate: mismatch");
         $finish;
      end
   end

   // Response back-pressure
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else       rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   // Window geometry per entry
   function automatic int unsigned win_shift(input int unsigned idx);
      if (idx < 156) return 20;
      if (idx < 166) return 21;
      return 24;
   endfunction

   function automatic logic [28:0] entry_base(input int unsigned idx);
      if (idx < 156) return 29'(idx) << 20;
      if (idx < 166) return 29'h9C0_0000 + (29'(idx - 156) << 21);
      return 29'hB00_0000 + (29'(idx - 166) << 24);
   endfunction

   // Descriptor with address, coordinate, ordering and the spare bit in place
   function automatic logic [63:0] build_desc(input int unsigned idx, input logic [1:0] ord,
                                              input logic [11:0] coord,
                                              input logic [35:0] abits, input bit spare);
      int unsigned n;
      logic [63:0] d;
      n = LOCAL_ADDR_W - win_shift(idx);
      d = 64'(abits) & ((64'd1 << n) - 64'd1);
      d = d | (64'(coord) << n) | (64'(ord) << (n + 26)) | (64'(spare) << (n + 29));
      return d;
   endfunction

   // Set one reserved bit of a descriptor
   function automatic logic [63:0] taint_desc(input int unsigned idx, input logic [63:0] d);
      int unsigned n;
      int unsigned b;
      n = LOCAL_ADDR_W - win_shift(idx);
      b = $urandom_range(63, n + 12);
      if (b >= n + 26 && b <= n + 27 || b == n + 29) b = 63;
      return d | (64'd1 << b);
   endfunction

   function automatic int unsigned pick_entry();
      int unsigned hot [10] = '{0, 1, 2, 155, 156, 157, 165, 166, 167, 185};
      if ($urandom_range(9) < 6) return hot[$urandom_range(9)];
      return $urandom_range(185);
   endfunction

   function automatic logic [1:0] pick_ordering();
      if ($urandom_range(9) == 0) return ORDER_RESERVED;
      return 2'($urandom_range(2));
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // One request transfer, with random idle cycles ahead of it
   task automatic send_item(input op_type op, input logic [28:0] offset,
                            input logic [24:0] size, input logic [63:0] data);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {2'b0, data, size, offset};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Hold the request side until every predicted response has arrived
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic send_translate(input int unsigned idx, input logic [28:0] inwin,
                                 input logic [24:0] size);
      send_item(OP_TRANSLATE, entry_base(idx) + inwin, size, rand64());
   endtask

   task automatic send_full(input int unsigned idx, input logic [63:0] d);
      send_item(OP_WRITE_FULL, 29'(idx) << 3, 25'($urandom), d);
   endtask

   // Directed part: boundaries, every status and both write forms
   task automatic run_directed();
      logic [63:0] d;
      send_translate(0, 29'd0, 25'd1);
      send_full(0, build_desc(0, 2'd2, 12'hFFF, 36'hF_FFFF_FFFF, 1'b1));
      send_translate(0, 29'd0, 25'h10_0000);
      send_translate(0, 29'hF_FFFF, 25'd1);
      send_translate(0, 29'd1, 25'h10_0000);
      d = build_desc(1, ORDER_RESERVED, 12'h3C5, 36'h0_0000_A5A5, 1'b0);
      send_item(OP_WRITE_HALF, 29'd8, 25'd0, {32'hFFFF_FFFF, d[31:0]});
      send_item(OP_WRITE_HALF, 29'd12, 25'h1FF_FFFF, {32'hDEAD_BEEF, d[63:32]});
      send_translate(1, 29'h1234, 25'h100);
      // reserved bit and forbidden ordering together: reserved wins, overrun wins over both
      send_full(2, taint_desc(2, build_desc(2, ORDER_RESERVED, 12'h001, 36'h1, 1'b0)));
      send_translate(2, 29'hF_FFFF, 25'd2);
      send_translate(2, 29'hF_FFFF, 25'd1);
      send_full(156, build_desc(156, 2'd1, 12'h5A5, 36'h0_0000_7FFF, 1'b0));
      send_translate(156, 29'd0, 25'h20_0000);
      send_translate(155, 29'hF_FFFF, 25'd1);
      send_full(166, build_desc(166, 2'd0, 12'hA5A, 36'h0_0000_0ABC, 1'b1));
      send_translate(166, 29'd0, 25'h100_0000);
      send_full(185, {64{1'b1}});
      send_item(OP_TRANSLATE, 29'h1EFF_FFFF, 25'd1, 64'd0);
      // bad writes: misaligned and past the table
      send_item(OP_WRITE_FULL, 29'd4, 25'd1, {64{1'b1}});
      send_item(OP_WRITE_HALF, 29'd2, 25'd1, {64{1'b1}});
      send_item(OP_WRITE_FULL, 29'd1488, 25'd1, {64{1'b1}});
      send_item(OP_WRITE_HALF, 29'h1EFF_FFFC, 25'd1, {64{1'b1}});
      send_full(185, 64'd0);
      send_item(OP_TRANSLATE, 29'h1EFF_FFFF, 25'd1, 64'd0);
   endtask

   // Random part: mostly well-formed descriptors followed by accesses into them
   task automatic run_random(input int count);
      int          sent;
      int unsigned pick;
      int unsigned idx;
      int unsigned span;
      logic [28:0] inwin;
      logic [28:0] offset;
      logic [63:0] d;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(99);
         idx  = pick_entry();
         span = 1 << win_shift(idx);
         d    = build_desc(idx, pick_ordering(), 12'($urandom), 36'(rand64()), 1'($urandom));
         if ($urandom_range(9) == 0) d = taint_desc(idx, d);
         if (pick < 12) begin
            send_full(idx, d);
            sent += 1;
         end else if (pick < 22) begin
            // descriptor as two half transfers, either order
            if ($urandom_range(1)) begin
               send_item(OP_WRITE_HALF, 29'(idx) << 3, 25'($urandom), {$urandom, d[31:0]});
               send_item(OP_WRITE_HALF, (29'(idx) << 3) | 29'd4, 25'($urandom),
                         {$urandom, d[63:32]});
            end else begin
               send_item(OP_WRITE_HALF, (29'(idx) << 3) | 29'd4, 25'($urandom),
                         {$urandom, d[63:32]});
               send_item(OP_WRITE_HALF, 29'(idx) << 3, 25'($urandom), {$urandom, d[31:0]});
            end
            sent += 2;
         end else if (pick < 27) begin
            send_full(idx, rand64());
            sent += 1;
         end else if (pick < 30) begin
            send_item(OP_WRITE_HALF, (29'(idx) << 3) | (29'($urandom_range(1)) << 2),
                      25'($urandom), rand64());
            sent += 1;
         end else if (pick < 35) begin
            offset = 29'($urandom_range(1487));
            case ($urandom_range(2))
               0: send_item(OP_WRITE_FULL, (offset & ~29'd7) | 29'($urandom_range(7, 1)),
                            25'($urandom), rand64());
               1: send_item(OP_WRITE_HALF, (offset & ~29'd3) | 29'($urandom_range(3, 1)),
                            25'($urandom), rand64());
               default: send_item($urandom_range(1) ? OP_WRITE_FULL : OP_WRITE_HALF,
                                  29'($urandom_range(29'h1EFF_FFF8, 1488)) & ~29'd7,
                                  25'($urandom), rand64());
            endcase
            sent += 1;
         end else if (pick < 40) begin
            // anywhere in the offset range, past the last window included
            send_item(OP_TRANSLATE, 29'($urandom_range(29'h1FFF_FFFF)),
                      25'($urandom_range(25'h100_0000, 1)), rand64());
            sent += 1;
         end else begin
            inwin = 29'($urandom_range(span - 1));
            pick  = $urandom_range(9);
            if (pick < 7) begin
               send_translate(idx, inwin, 25'($urandom_range(span - inwin, 1)));
            end else if (pick < 8) begin
               send_translate(idx, 29'd0, 25'(span));
            end else begin
               if (inwin == '0) inwin = 29'd1;
               send_translate(idx, inwin, 25'($urandom_range(span, span - inwin + 1)));
            end
            sent += 1;
         end
      end
   endtask

   // Stimulus and verdict
   initial begin
      reset             <= 1'b1;
      req_tvalid        <= 1'b0;
      req_tuser         <= '0;
      req_tdata         <= '0;
      sender_idle_pct   = 14;
      receiver_idle_pct = 73;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      run_random(RANDOM_ITEMS);
      drain();

      sender_idle_pct   = 73;
      receiver_idle_pct = 14;
      run_random(RANDOM_ITEMS);
      drain();

      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      run_random(RANDOM_ITEMS);
      drain();

      repeat (10) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("pcie_window_tlb_translate: match");
      end else begin
         $display("pcie_window_tlb_translate: mismatch");
      end
      $finish;
   end

endmodule
